[rtl/core/vnue_pkg.sv]
// ----------------------------------------------------------------------------
// vnue_pkg
// Types and constants shared by the variable nibble encoder modules.
// ----------------------------------------------------------------------------
package vnue_pkg;

	localparam int COUNT_W = 4;
	localparam int NIB_W   = 5;

	localparam logic [COUNT_W-1:0] MAX_FIXED = 4'd8;
	localparam logic [2:0]         GROUP_MASK = 3'h7;

	// Per-item command decided by the front end
	typedef struct packed {
		logic               fixed;
		logic [COUNT_W-1:0] count;
	} cmd_t;

	// Queue status seen by the top level
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

[rtl/core/variable_nibble_uint_encoder.sv]
// ----------------------------------------------------------------------------
// variable_nibble_uint_encoder
// Encodes an unsigned integer as fixed little-endian bytes or as chained
// 3-bit groups packed two per byte.
// ----------------------------------------------------------------------------
// The emitter produces one byte per cycle unless out_stall holds the output
// register. An item gives fixed_bytes (saturated at 8) bytes in fixed mode,
// ceil(significant bits / 6) with a minimum of one in compressed mode,
// up to six for a 32-bit value. The next queued item is loaded in the same
// cycle the last byte of the previous one is issued. A two-entry queue sits
// between input classification and the emitter, and a single registered
// output stage holds each byte while out_stall is high; the emitter pauses
// until that byte is taken.
module variable_nibble_uint_encoder
	import vnue_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        value,
	input  logic [COUNT_W-1:0] fixed_bytes,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               last,
	output logic [NIB_W-1:0]   nibble_total
);

	localparam int QW = VALUE_BITS + $bits(cmd_t);

	logic [VALUE_BITS-1:0] value_m;
	cmd_t                  cmd;
	logic                  push;
	logic                  pop;
	logic [QW-1:0]         q_data;
	fifo_stat_t            fstat;
	cmd_t                  q_cmd;
	logic [VALUE_BITS-1:0] q_value;

	vnue_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.value       (value),
		.fixed_bytes (fixed_bytes),
		.value_m     (value_m),
		.cmd         (cmd)
	);

	assign in_stall = fstat.full;
	assign push     = in_valid && !fstat.full;

	vnue_fifo #(.WIDTH(QW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({value_m, cmd}),
		.pop    (pop),
		.rdata  (q_data),
		.stat   (fstat)
	);

	assign q_value = q_data[QW-1 -: VALUE_BITS];
	assign q_cmd   = q_data[$bits(cmd_t)-1:0];

	vnue_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (!fstat.empty),
		.q_value      (q_value),
		.q_cmd        (q_cmd),
		.q_pop        (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last         (last),
		.nibble_total (nibble_total)
	);

	a_total_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> nibble_total == '0)
		else $error("nibble_total set on a non-final byte");

	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> nibble_total != '0)
		else $error("final byte carries zero nibble count");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> !fstat.empty)
		else $error("accepted transfer missing from queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fstat.empty)
		else $error("queue popped while empty");

endmodule

[rtl/core/vnue_front.sv]
// ----------------------------------------------------------------------------
// vnue_front
// Classifies an incoming item: masks the value and saturates the byte count.
// ----------------------------------------------------------------------------
module vnue_front
	import vnue_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic [31:0]           value,
	input  logic [COUNT_W-1:0]    fixed_bytes,
	output logic [VALUE_BITS-1:0] value_m,
	output cmd_t                  cmd
);

	logic [63:0] value_wide;

	assign value_wide = 64'(value);
	assign value_m    = value_wide[VALUE_BITS-1:0];

	always_comb begin
		cmd.fixed = (fixed_bytes != '0);
		cmd.count = (fixed_bytes > MAX_FIXED) ? MAX_FIXED : fixed_bytes;
	end

endmodule

[rtl/core/vnue_fifo.sv]
// ----------------------------------------------------------------------------
// vnue_fifo
// Two-entry queue between the front end and the byte emitter.
// ----------------------------------------------------------------------------
module vnue_fifo #(
	parameter int WIDTH = 37
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [WIDTH-1:0]       wdata,
	input  logic                   pop,
	output logic [WIDTH-1:0]       rdata,
	output vnue_pkg::fifo_stat_t   stat
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign rdata      = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

endmodule

[rtl/core/vnue_back.sv]
// ----------------------------------------------------------------------------
// vnue_back
// Byte emitter: walks a queued item, one encoded byte a cycle unless stalled.
// ----------------------------------------------------------------------------
module vnue_back
	import vnue_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  logic [VALUE_BITS-1:0] q_value,
	input  cmd_t                  q_cmd,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte,
	output logic                  last,
	output logic [NIB_W-1:0]      nibble_total
);

	logic                  busy_q;
	logic                  fixed_q;
	logic [COUNT_W-1:0]    cnt_q;
	logic [VALUE_BITS-1:0] v_q;
	logic [NIB_W-1:0]      nib_q;

	logic                  ov_q;
	logic [7:0]            byte_q;
	logic                  last_q;
	logic [NIB_W-1:0]      tot_q;

	logic                  emit;
	logic [VALUE_BITS-1:0] rest;
	logic [VALUE_BITS-1:0] rest2;
	logic                  more1;
	logic                  more2;
	logic [7:0]            byte_c;
	logic                  last_c;
	logic [NIB_W-1:0]      nib_next;

	assign emit  = busy_q && (!ov_q || !out_stall);
	assign q_pop = q_valid && (!busy_q || (emit && last_c));

	always_comb begin
		rest  = v_q >> 3;
		rest2 = v_q >> 6;
		more1 = (rest != '0);
		more2 = (rest2 != '0);
		if (fixed_q) begin
			byte_c   = v_q[7:0];
			last_c   = (cnt_q == COUNT_W'(1));
			nib_next = nib_q + NIB_W'(2);
		end else begin
			byte_c   = {more2, (more1 ? rest[2:0] : 3'b000), more1, v_q[2:0] & GROUP_MASK};
			last_c   = !more2;
			nib_next = nib_q + (more1 ? NIB_W'(2) : NIB_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (emit && last_c) begin
				busy_q <= 1'b0;
			end
			if (!ov_q || !out_stall) begin
				ov_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			v_q     <= q_value;
			cnt_q   <= q_cmd.count;
			fixed_q <= q_cmd.fixed;
			nib_q   <= '0;
		end else if (emit) begin
			v_q   <= fixed_q ? (v_q >> 8) : rest2;
			cnt_q <= cnt_q - COUNT_W'(1);
			nib_q <= nib_next;
		end
		if (emit) begin
			byte_q <= byte_c;
			last_q <= last_c;
			tot_q  <= last_c ? nib_next : '0;
		end
	end

	assign out_valid    = ov_q;
	assign out_byte     = byte_q;
	assign last         = last_q;
	assign nibble_total = tot_q;

endmodule
